>>> rtl/bsad_pkg.sv
// ----------------------------------------------------------------------------
// bsad_pkg
// Shared widths, target codes and memory map constants of the bank switching
// address decoder.
// ----------------------------------------------------------------------------
package bsad_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;
  localparam int unsigned TgtW  = 3;
  localparam int unsigned BankW = 3;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [DataW-1:0] data_t;
  typedef logic [BankW-1:0] bank_t;

  typedef enum logic [TgtW-1:0] {
    TgtNone   = 3'd0,
    TgtRam    = 3'd1,
    TgtBasic  = 3'd2,
    TgtKernal = 3'd3,
    TgtChar   = 3'd4,
    TgtVideo  = 3'd5,
    TgtColour = 3'd6,
    TgtIoChip = 3'd7
  } target_e;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } opcode_e;

  localparam bank_t BankReset    = 3'h7;
  localparam data_t PortDirValue = 8'h2F;
  localparam data_t HoleValue    = 8'h00;

  localparam addr_t PortDirAddr  = 16'h0000;
  localparam addr_t BankAddr     = 16'h0001;
  localparam addr_t BasicBase    = 16'hA000;
  localparam addr_t BasicLast    = 16'hBFFF;
  localparam addr_t DBlockBase   = 16'hD000;
  localparam addr_t DBlockLast   = 16'hDFFF;
  localparam addr_t VideoLast    = 16'hD3FF;
  localparam addr_t ColourBase   = 16'hD800;
  localparam addr_t ColourLast   = 16'hDBE7;
  localparam addr_t IoChipBase   = 16'hDC00;
  localparam addr_t IoChipLast   = 16'hDDFF;
  localparam addr_t KernalBase   = 16'hE000;

endpackage

>>> rtl/bsad_if.sv
// ----------------------------------------------------------------------------
// bsad_if
// Valid/ready channels of the decoder: bus access in, decode result out.
// ----------------------------------------------------------------------------
interface bsad_req_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  bsad_pkg::addr_t     address;
  bsad_pkg::data_t     write_data;

  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input address, input write_data,
                  output ready);
endinterface

interface bsad_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bsad_pkg::TgtW-1:0]  target;
  bsad_pkg::addr_t            target_offset;
  logic                       target_write;
  bsad_pkg::data_t            direct_data;
  logic                       low_nibble_only;

  modport source (output valid, output target, output target_offset,
                  output target_write, output direct_data, output low_nibble_only,
                  input ready);
  modport sink   (input valid, input target, input target_offset,
                  input target_write, input direct_data, input low_nibble_only,
                  output ready);
endinterface

>>> rtl/bank_switching_address_decoder_top.sv
// ----------------------------------------------------------------------------
// bank_switching_address_decoder_top
// Decodes one processor bus access per transfer into a target, an offset,
// a write enable and direct read data, under a 3-bit bank select register.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  in_i     in   opcode, address, write_data                      valid/ready
//  out_o    out  target, target_offset, target_write,             valid/ready
//                direct_data, low_nibble_only
//
//  one transfer per cycle sustained while results are taken: input register,
//  one decode step, result register; a stalled result holds the result stage
//  and a full input stage; bank select is updated as the bank write leaves
//  the input register; reset clears valids, bank select to 7
// ----------------------------------------------------------------------------
module bank_switching_address_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  bsad_req_if.sink           in_i,
  bsad_rsp_if.source         out_o
);

  logic                       s1_valid_q;
  logic                       s1_opcode_q;
  bsad_pkg::addr_t            s1_addr_q;
  bsad_pkg::data_t            s1_data_q;
  bsad_pkg::bank_t            bank_q, bank_d;

  logic                       out_valid_q;
  logic [bsad_pkg::TgtW-1:0]  tgt_q, tgt_d;
  bsad_pkg::addr_t            off_q, off_d;
  logic                       wr_q, wr_d;
  bsad_pkg::data_t            direct_q, direct_d;
  logic                       nib_q, nib_d;

  logic                       out_free;
  logic                       advance;
  logic                       in_xfer;

  assign out_free  = !out_valid_q || out_o.ready;
  assign advance   = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_xfer   = in_i.valid && in_i.ready;

  // decode
  logic io_video, io_colour, io_iochip, dblock, is_write;
  bsad_pkg::addr_t a;

  always_comb begin
    a         = s1_addr_q;
    is_write  = (s1_opcode_q == bsad_pkg::OpWrite);
    dblock    = (a >= bsad_pkg::DBlockBase) && (a <= bsad_pkg::DBlockLast) &&
                (bank_q[1:0] != 2'b00);
    io_video  = (a >= bsad_pkg::DBlockBase) && (a <= bsad_pkg::VideoLast);
    io_colour = (a >= bsad_pkg::ColourBase) && (a <= bsad_pkg::ColourLast);
    io_iochip = (a >= bsad_pkg::IoChipBase) && (a <= bsad_pkg::IoChipLast);

    tgt_d    = bsad_pkg::TgtNone;
    off_d    = '0;
    wr_d     = 1'b0;
    direct_d = '0;
    nib_d    = 1'b0;
    bank_d   = bank_q;

    if (is_write) begin
      if (a == bsad_pkg::PortDirAddr) begin
        tgt_d = bsad_pkg::TgtNone;
      end else if (a == bsad_pkg::BankAddr) begin
        bank_d = s1_data_q[bsad_pkg::BankW-1:0];
      end else if (dblock && bank_q[2]) begin
        if (io_video) begin
          tgt_d = bsad_pkg::TgtVideo;
          off_d = a - bsad_pkg::DBlockBase;
          wr_d  = 1'b1;
        end else if (io_colour) begin
          tgt_d = bsad_pkg::TgtColour;
          off_d = a - bsad_pkg::ColourBase;
          wr_d  = 1'b1;
        end else if (io_iochip) begin
          tgt_d = bsad_pkg::TgtIoChip;
          off_d = a - bsad_pkg::IoChipBase;
          wr_d  = 1'b1;
        end
      end else begin
        tgt_d = bsad_pkg::TgtRam;
        off_d = a;
        wr_d  = 1'b1;
      end
    end else begin
      if (a == bsad_pkg::PortDirAddr) begin
        direct_d = bsad_pkg::PortDirValue;
      end else if (a == bsad_pkg::BankAddr) begin
        direct_d = {{(bsad_pkg::DataW-bsad_pkg::BankW){1'b0}}, bank_q};
      end else if ((a >= bsad_pkg::BasicBase) && (a <= bsad_pkg::BasicLast) &&
                   (bank_q[1:0] == 2'b11)) begin
        tgt_d = bsad_pkg::TgtBasic;
        off_d = a - bsad_pkg::BasicBase;
      end else if (dblock) begin
        if (bank_q[2]) begin
          if (io_video) begin
            tgt_d = bsad_pkg::TgtVideo;
            off_d = a - bsad_pkg::DBlockBase;
          end else if (io_colour) begin
            tgt_d = bsad_pkg::TgtColour;
            off_d = a - bsad_pkg::ColourBase;
            nib_d = 1'b1;
          end else if (io_iochip) begin
            tgt_d = bsad_pkg::TgtIoChip;
            off_d = a - bsad_pkg::IoChipBase;
          end else begin
            direct_d = bsad_pkg::HoleValue;
          end
        end else begin
          tgt_d = bsad_pkg::TgtChar;
          off_d = a - bsad_pkg::DBlockBase;
        end
      end else if ((a >= bsad_pkg::KernalBase) && bank_q[1]) begin
        tgt_d = bsad_pkg::TgtKernal;
        off_d = a - bsad_pkg::KernalBase;
      end else begin
        tgt_d = bsad_pkg::TgtRam;
        off_d = a;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bank_q      <= bsad_pkg::BankReset;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (advance) begin
        bank_q <= bank_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_opcode_q <= in_i.opcode;
      s1_addr_q   <= in_i.address;
      s1_data_q   <= in_i.write_data;
    end
    if (advance) begin
      tgt_q    <= tgt_d;
      off_q    <= off_d;
      wr_q     <= wr_d;
      direct_q <= direct_d;
      nib_q    <= nib_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.target          = tgt_q;
  assign out_o.target_offset   = off_q;
  assign out_o.target_write    = wr_q;
  assign out_o.direct_data     = direct_q;
  assign out_o.low_nibble_only = nib_q;

  // assertions
  a_bank_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && is_write && (s1_addr_q == bsad_pkg::BankAddr)) |=> $stable(bank_q))
    else $error("bank select changed without a bank write");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.ready && s1_valid_q) |-> advance)
    else $error("input stage overwritten while holding an item");

  a_write_has_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && wr_q) |-> (tgt_q != bsad_pkg::TgtNone))
    else $error("write enable without a target");

  a_nibble_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && nib_q) |-> ((tgt_q == bsad_pkg::TgtColour) && !wr_q))
    else $error("nibble mask outside colour ram read");

  a_direct_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (direct_q != '0)) |-> (tgt_q == bsad_pkg::TgtNone))
    else $error("direct data with a target selected");

endmodule

>>> dv/bsad_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsad_checker
// Watches both channels of the bank switching address decoder. Every access
// taken in is decoded against a private copy of the bank select register and
// the decode is queued; every result given out is compared field by field
// with the oldest queued decode. Mismatches are printed and counted.
// ----------------------------------------------------------------------------
module bsad_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bsad_req_if  req,
  bsad_rsp_if  rsp,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct packed {
    bsad_pkg::target_e target;
    bsad_pkg::addr_t   offset;
    logic              wr;
    bsad_pkg::data_t   direct;
    logic              nib;
  } decode_t;

  bsad_pkg::bank_t bank_q;
  decode_t         pending_decodes[$];
  decode_t         want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("%0t mismatch on %0s: got 0x%0h, want 0x%0h", $realtime, what, got, exp_val);
    fail_count_o++;
  endtask

  // mapped i/o block, leaves target none for a hole
  function automatic decode_t io_map(input bsad_pkg::addr_t addr);
    decode_t d;
    d = '0;
    if (addr >= bsad_pkg::DBlockBase && addr <= bsad_pkg::VideoLast) begin
      d.target = bsad_pkg::TgtVideo;
      d.offset = addr - bsad_pkg::DBlockBase;
    end else if (addr >= bsad_pkg::ColourBase && addr <= bsad_pkg::ColourLast) begin
      d.target = bsad_pkg::TgtColour;
      d.offset = addr - bsad_pkg::ColourBase;
    end else if (addr >= bsad_pkg::IoChipBase && addr <= bsad_pkg::IoChipLast) begin
      d.target = bsad_pkg::TgtIoChip;
      d.offset = addr - bsad_pkg::IoChipBase;
    end
    return d;
  endfunction

  function automatic decode_t decode_access(input bsad_pkg::opcode_e op,
                                            input bsad_pkg::addr_t  addr,
                                            input bsad_pkg::bank_t  bank);
    decode_t d;
    logic    in_dblk;
    d       = '0;
    in_dblk = (addr >= bsad_pkg::DBlockBase) && (addr <= bsad_pkg::DBlockLast) &&
              (bank[1:0] != 2'b00);
    if (op == bsad_pkg::OpWrite) begin
      if (addr == bsad_pkg::PortDirAddr || addr == bsad_pkg::BankAddr) begin
        d = '0;
      end else if (in_dblk && bank[2]) begin
        d    = io_map(addr);
        d.wr = (d.target != bsad_pkg::TgtNone);
      end else begin
        d.target = bsad_pkg::TgtRam;
        d.offset = addr;
        d.wr     = 1'b1;
      end
    end else begin
      if (addr == bsad_pkg::PortDirAddr) begin
        d.direct = bsad_pkg::PortDirValue;
      end else if (addr == bsad_pkg::BankAddr) begin
        d.direct = bsad_pkg::data_t'(bank);
      end else if (addr >= bsad_pkg::BasicBase && addr <= bsad_pkg::BasicLast &&
                   bank[1:0] == 2'b11) begin
        d.target = bsad_pkg::TgtBasic;
        d.offset = addr - bsad_pkg::BasicBase;
      end else if (in_dblk) begin
        if (bank[2]) begin
          d = io_map(addr);
          if (d.target == bsad_pkg::TgtColour) d.nib = 1'b1;
          if (d.target == bsad_pkg::TgtNone) d.direct = bsad_pkg::HoleValue;
        end else begin
          d.target = bsad_pkg::TgtChar;
          d.offset = addr - bsad_pkg::DBlockBase;
        end
      end else if (addr >= bsad_pkg::KernalBase && bank[1]) begin
        d.target = bsad_pkg::TgtKernal;
        d.offset = addr - bsad_pkg::KernalBase;
      end else begin
        d.target = bsad_pkg::TgtRam;
        d.offset = addr;
      end
    end
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= bsad_pkg::BankReset;
      pending_decodes.delete();
      pending_o <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_decodes.size() == 0) begin
          flag_mismatch("result with nothing pending", int'(rsp.target_offset), 0);
        end else begin
          want = pending_decodes.pop_front();
          if (rsp.target !== want.target)
            flag_mismatch("target", int'(rsp.target), int'(want.target));
          if (rsp.target_offset !== want.offset)
            flag_mismatch("target_offset", int'(rsp.target_offset), int'(want.offset));
          if (rsp.target_write !== want.wr)
            flag_mismatch("target_write", int'(rsp.target_write), int'(want.wr));
          if (rsp.direct_data !== want.direct)
            flag_mismatch("direct_data", int'(rsp.direct_data), int'(want.direct));
          if (rsp.low_nibble_only !== want.nib)
            flag_mismatch("low_nibble_only", int'(rsp.low_nibble_only), int'(want.nib));
          checked_o <= checked_o + 1;
        end
      end
      if (req.valid && req.ready) begin
        pending_decodes.push_back(decode_access(bsad_pkg::opcode_e'(req.opcode),
                                                req.address, bank_q));
        if (req.opcode == bsad_pkg::OpWrite && req.address == bsad_pkg::BankAddr) begin
          bank_q <= req.write_data[bsad_pkg::BankW-1:0];
        end
      end
      pending_o <= pending_decodes.size();
    end
  end

endmodule

>>> dv/tb_bank_switching_address_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bank_switching_address_decoder_top
// Drives bus accesses into the decoder: a directed walk over the memory map
// edges and four bank settings, then random accesses under three idle
// patterns with a long output stall and a full drain. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bank_switching_address_decoder_top;

  localparam int RandPerPhase = 210;
  localparam int HoldCycles   = 80;

  localparam bsad_pkg::addr_t MapEdges [20] = '{
    16'h0002, 16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000, 16'hCFFF, 16'hD000,
    16'hD3FF, 16'hD400, 16'hD7FF, 16'hD800, 16'hDBE7, 16'hDBE8, 16'hDBFF,
    16'hDC00, 16'hDDFF, 16'hDE00, 16'hDFFF, 16'hE000, 16'hFFFF
  };

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   sink_idle_pct;
  bit   stall_req;
  int   items_sent;
  int   bank_writes;
  int   fail_count;
  int   pending;
  int   checked;

  bsad_req_if req_if ();
  bsad_rsp_if rsp_if ();

  bank_switching_address_decoder_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  bsad_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side, long hold-off counted here
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        repeat (HoldCycles) begin
          rsp_if.ready <= 1'b0;
          @(negedge clk_i);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_access(input bsad_pkg::opcode_e op, input bsad_pkg::addr_t addr,
                             input bsad_pkg::data_t data);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.address    <= addr;
    req_if.write_data <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (op == bsad_pkg::OpWrite && addr == bsad_pkg::BankAddr) bank_writes++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int                pick;
    bsad_pkg::opcode_e op;
    bsad_pkg::addr_t   addr;
    bsad_pkg::data_t   data;
    pick = $urandom_range(99);
    op   = bsad_pkg::opcode_e'($urandom_range(1));
    data = bsad_pkg::data_t'($urandom_range(255));
    if (pick < 8) begin
      op   = bsad_pkg::OpWrite;
      addr = bsad_pkg::BankAddr;
    end else if (pick < 12) begin
      addr = bsad_pkg::addr_t'($urandom_range(1));
    end else if (pick < 32) begin
      addr = MapEdges[$urandom_range(19)];
    end else if (pick < 65) begin
      addr = bsad_pkg::DBlockBase + bsad_pkg::addr_t'($urandom_range(4095));
    end else if (pick < 80) begin
      addr = ($urandom_range(1) ? bsad_pkg::BasicBase : bsad_pkg::KernalBase) +
             bsad_pkg::addr_t'($urandom_range(8191));
    end else begin
      addr = bsad_pkg::addr_t'($urandom_range(65535));
    end
    send_access(op, addr, data);
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.opcode     = bsad_pkg::OpRead;
    req_if.address    = '0;
    req_if.write_data = '0;
    src_idle_pct      = 35;
    sink_idle_pct     = 76;
    stall_req         = 1'b0;
    items_sent        = 0;
    bank_writes       = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed walk, reset bank first
    send_access(bsad_pkg::OpRead,  bsad_pkg::BankAddr,    8'h00);
    send_access(bsad_pkg::OpRead,  bsad_pkg::PortDirAddr, 8'hFF);
    send_access(bsad_pkg::OpWrite, bsad_pkg::PortDirAddr, 8'hFF);
    send_access(bsad_pkg::OpRead,  16'hA000,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hBFFF,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hD000,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hD3FF,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hD400,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hD800,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hDBE7,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hDBE8,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hDC00,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hDDFF,              8'h00);
    send_access(bsad_pkg::OpRead,  16'hFFFF,              8'h00);
    send_access(bsad_pkg::OpWrite, 16'hDE00,              8'hA5);
    send_access(bsad_pkg::OpWrite, 16'hD000,              8'h5A);
    send_access(bsad_pkg::OpWrite, 16'hE000,              8'hFF);
    send_access(bsad_pkg::OpWrite, bsad_pkg::BankAddr,    8'h00);
    send_access(bsad_pkg::OpRead,  bsad_pkg::BankAddr,    8'h00);
    send_access(bsad_pkg::OpRead,  16'hD000,              8'h00);
    send_access(bsad_pkg::OpWrite, bsad_pkg::BankAddr,    8'hFB);
    send_access(bsad_pkg::OpRead,  16'hDFFF,              8'h00);
    send_access(bsad_pkg::OpWrite, 16'hD000,              8'h00);
    send_access(bsad_pkg::OpWrite, bsad_pkg::BankAddr,    8'h06);
    send_access(bsad_pkg::OpRead,  16'hE000,              8'h00);

    repeat (RandPerPhase / 2) send_random();
    drain_results();
    repeat (RandPerPhase / 2) send_random();
    drain_results();

    src_idle_pct  = 76;
    sink_idle_pct = 35;
    repeat (RandPerPhase) send_random();
    drain_results();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_req     = 1'b1;
    repeat (RandPerPhase) send_random();
    drain_results();

    repeat (10) @(negedge clk_i);
    $display("covered %0d accesses with %0d bank writes over three idle patterns",
             items_sent, bank_writes);
    $display("compared %0d results, including a long output hold-off", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bsad_pkg.sv
rtl/bsad_if.sv
rtl/bank_switching_address_decoder_top.sv
dv/bsad_checker.sv
dv/tb_bank_switching_address_decoder_top.sv
